// File: hdl/vfc_pkg.sv
// Shared types and constants for the voxel face culling mesher.
// Holds command and face codes, the quad corner table and control structs.
// No dependencies.
`timescale 1ns / 1ps

package vfc_pkg;

	// default chunk edge length in cells
	localparam int CHUNK_EDGE_DEF = 32;

	localparam int CELL_W   = 5;   // input coordinate width
	localparam int VPOS_W   = 6;   // vertex coordinate width
	localparam int TYPE_W   = 8;   // block type width
	localparam int VIDX_W   = 19;  // vertex index width
	localparam int FACES    = 6;

	// command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_BEGIN = 2'd1;
	localparam logic [1:0] CMD_EMIT  = 2'd2;

	// face direction codes
	localparam logic [2:0] FACE_POS_Z = 3'd0;
	localparam logic [2:0] FACE_NEG_Z = 3'd1;
	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;
	localparam logic [2:0] FACE_POS_X = 3'd4;
	localparam logic [2:0] FACE_NEG_X = 3'd5;

	localparam logic [1:0] CORNER_LAST = 2'd3;

	// corner offsets of each face quad, packed as {dx, dy, dz}
	localparam logic [2:0] QUAD_CORNER [FACES][4] = '{
		'{3'b001, 3'b101, 3'b111, 3'b011},
		'{3'b100, 3'b000, 3'b010, 3'b110},
		'{3'b010, 3'b011, 3'b111, 3'b110},
		'{3'b100, 3'b101, 3'b001, 3'b000},
		'{3'b101, 3'b100, 3'b110, 3'b111},
		'{3'b000, 3'b001, 3'b011, 3'b010}
	};

	// sequencer to vertex emitter
	typedef struct packed {
		logic                go;
		logic                clear_count;
		logic [FACES-1:0]    mask;
		logic [CELL_W-1:0]   x;
		logic [CELL_W-1:0]   y;
		logic [CELL_W-1:0]   z;
	} emit_ctrl_t;

	// vertex emitter to sequencer
	typedef struct packed {
		logic active;
	} emit_stat_t;

endpackage

// File: hdl/voxel_face_culling_mesher.sv
// Voxel face culling mesher: write and begin commands complete on acceptance and leave busy low.
// An emit command probes the cell and six neighbors, one store read a cycle, then decides;
// when the cell is solid with a face exposed, the emitter strobes one vertex a cycle, four per
// exposed face, with busy high until the last one. After reset the store is cleared one entry
// a cycle, all CHUNK_EDGE^3 entries (32768 by default), with busy high. Results cannot be held
// off by the receiver.
`timescale 1ns / 1ps

module voxel_face_culling_mesher #(
	parameter int CHUNK_EDGE = vfc_pkg::CHUNK_EDGE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   command,
	input  logic [vfc_pkg::CELL_W-1:0]   cell_x,
	input  logic [vfc_pkg::CELL_W-1:0]   cell_y,
	input  logic [vfc_pkg::CELL_W-1:0]   cell_z,
	input  logic [vfc_pkg::TYPE_W-1:0]   block_type,
	output logic                         strobe,
	output logic [vfc_pkg::VPOS_W-1:0]   vertex_x,
	output logic [vfc_pkg::VPOS_W-1:0]   vertex_y,
	output logic [vfc_pkg::VPOS_W-1:0]   vertex_z,
	output logic [2:0]                   face_dir,
	output logic [1:0]                   corner,
	output logic [vfc_pkg::VIDX_W-1:0]   vertex_index,
	output logic                         last
);

	localparam int DEPTH = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] EDGE_A  = AW'(CHUNK_EDGE);
	localparam logic [AW-1:0] PLANE_A = AW'(CHUNK_EDGE * CHUNK_EDGE);
	localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

	// probe steps: center first, then the faces in emit order
	localparam logic [2:0] STEP_CENTER = 3'd0;
	localparam logic [2:0] STEP_POS_Z  = 3'd1;
	localparam logic [2:0] STEP_NEG_Z  = 3'd2;
	localparam logic [2:0] STEP_POS_Y  = 3'd3;
	localparam logic [2:0] STEP_NEG_Y  = 3'd4;
	localparam logic [2:0] STEP_POS_X  = 3'd5;
	localparam logic [2:0] STEP_NEG_X  = 3'd6;
	localparam logic [2:0] STEP_DONE   = 3'd7;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	state_t                         state_q;
	logic [AW-1:0]                  clr_q;
	logic [vfc_pkg::CELL_W-1:0]     x_q, y_q, z_q;
	logic [2:0]                     rd_step_q;
	logic                           valid_s1;
	logic [2:0]                     step_s1;
	logic                           inside_s1;
	logic                           solid_q;
	logic [vfc_pkg::FACES-1:0]      mask_q;

	logic                           accept;
	logic                           cell_in;
	logic [vfc_pkg::VPOS_W-1:0]     nx, ny, nz;
	logic                           rd_in;
	logic [AW-1:0]                  raddr;
	logic [vfc_pkg::TYPE_W-1:0]     rdata;
	logic                           we;
	logic [AW-1:0]                  waddr;
	logic [vfc_pkg::TYPE_W-1:0]     wdata;

	vfc_pkg::emit_ctrl_t            ectrl;
	vfc_pkg::emit_stat_t            estat;

	function automatic logic [AW-1:0] cell_addr(input logic [vfc_pkg::VPOS_W-1:0] ax,
	                                            input logic [vfc_pkg::VPOS_W-1:0] ay,
	                                            input logic [vfc_pkg::VPOS_W-1:0] az);
		cell_addr = AW'(ax) + AW'(ay) * EDGE_A + AW'(az) * PLANE_A;
	endfunction

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign cell_in = (int'(cell_x) < CHUNK_EDGE) && (int'(cell_y) < CHUNK_EDGE) &&
	                 (int'(cell_z) < CHUNK_EDGE);

	// form the probe coordinate and its in-chunk test
	always_comb begin
		nx    = {1'b0, x_q};
		ny    = {1'b0, y_q};
		nz    = {1'b0, z_q};
		rd_in = (int'(x_q) < CHUNK_EDGE) && (int'(y_q) < CHUNK_EDGE) &&
		        (int'(z_q) < CHUNK_EDGE);
		case (rd_step_q)
			STEP_POS_Z: begin
				nz    = nz + 1'b1;
				rd_in = rd_in && (int'(nz) < CHUNK_EDGE);
			end
			STEP_NEG_Z: begin
				rd_in = rd_in && (z_q != '0);
				nz    = nz - 1'b1;
			end
			STEP_POS_Y: begin
				ny    = ny + 1'b1;
				rd_in = rd_in && (int'(ny) < CHUNK_EDGE);
			end
			STEP_NEG_Y: begin
				rd_in = rd_in && (y_q != '0);
				ny    = ny - 1'b1;
			end
			STEP_POS_X: begin
				nx    = nx + 1'b1;
				rd_in = rd_in && (int'(nx) < CHUNK_EDGE);
			end
			STEP_NEG_X: begin
				rd_in = rd_in && (x_q != '0);
				nx    = nx - 1'b1;
			end
			default: begin
			end
		endcase
		raddr = rd_in ? cell_addr(nx, ny, nz) : '0;
	end

	// write port: clearing sweep, or a voxel write on accept
	always_comb begin
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			we    = accept && (command == vfc_pkg::CMD_WRITE) && cell_in;
			waddr = cell_addr({1'b0, cell_x}, {1'b0, cell_y}, {1'b0, cell_z});
			wdata = block_type;
		end
	end

	vfc_ram #(
		.WIDTH(vfc_pkg::TYPE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// control to the emitter
	always_comb begin
		ectrl.go          = (state_q == ST_DECIDE) && solid_q && (mask_q != '0);
		ectrl.clear_count = accept && (command == vfc_pkg::CMD_BEGIN);
		ectrl.mask        = mask_q;
		ectrl.x           = x_q;
		ectrl.y           = y_q;
		ectrl.z           = z_q;
	end

	// sequencer: clear sweep, command decode, neighbor probe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			rd_step_q <= STEP_CENTER;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1  <= (state_q == ST_PROBE) && (rd_step_q != STEP_DONE);
			step_s1   <= rd_step_q;
			inside_s1 <= rd_in;

			// fold returned store data into the solid flag and face mask
			if (valid_s1) begin
				if (step_s1 == STEP_CENTER) begin
					solid_q <= inside_s1 && (rdata != '0);
				end else begin
					mask_q[step_s1 - 3'd1] <= !inside_s1 || (rdata == '0);
				end
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_A) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (command == vfc_pkg::CMD_EMIT)) begin
						x_q       <= cell_x;
						y_q       <= cell_y;
						z_q       <= cell_z;
						rd_step_q <= STEP_CENTER;
						state_q   <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (rd_step_q != STEP_DONE) begin
						rd_step_q <= rd_step_q + 1'b1;
					end
					if (valid_s1 && (step_s1 == STEP_NEG_X)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= ectrl.go ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (!estat.active) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	vfc_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ectrl),
		.stat        (estat),
		.strobe      (strobe),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.vertex_z    (vertex_z),
		.face_dir    (face_dir),
		.corner      (corner),
		.vertex_index(vertex_index),
		.last        (last)
	);

endmodule

// File: hdl/vfc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module vfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/vfc_emit.sv
// Vertex emitter: walks the exposed face mask and emits four corners per face.
// Holds the running vertex counter. Depends on vfc_pkg.
`timescale 1ns / 1ps

module vfc_emit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vfc_pkg::emit_ctrl_t              ctrl,
	output vfc_pkg::emit_stat_t              stat,
	output logic                             strobe,
	output logic [vfc_pkg::VPOS_W-1:0]       vertex_x,
	output logic [vfc_pkg::VPOS_W-1:0]       vertex_y,
	output logic [vfc_pkg::VPOS_W-1:0]       vertex_z,
	output logic [2:0]                       face_dir,
	output logic [1:0]                       corner,
	output logic [vfc_pkg::VIDX_W-1:0]       vertex_index,
	output logic                             last
);

	logic                          active_q;
	logic [vfc_pkg::FACES-1:0]     mask_q;
	logic [vfc_pkg::CELL_W-1:0]    x_q, y_q, z_q;
	logic [1:0]                    corner_q;
	logic [vfc_pkg::VIDX_W-1:0]    count_q;

	logic [2:0]                    cur_face;
	logic [vfc_pkg::FACES-1:0]     rest_mask;
	logic                          last_v;
	logic [2:0]                    offs;

	// pick the lowest exposed face still pending
	always_comb begin
		cur_face = vfc_pkg::FACE_POS_Z;
		for (int f = vfc_pkg::FACES - 1; f >= 0; f--) begin
			if (mask_q[f]) begin
				cur_face = 3'(f);
			end
		end
		rest_mask = mask_q & ~(vfc_pkg::FACES'(1) << cur_face);
		last_v    = (corner_q == vfc_pkg::CORNER_LAST) && (rest_mask == '0);
		offs      = vfc_pkg::QUAD_CORNER[cur_face][corner_q];
	end

	// sequence faces and corners, register one vertex per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe   <= 1'b0;
			count_q  <= '0;
		end else begin
			strobe <= 1'b0;
			if (ctrl.clear_count) begin
				count_q <= '0;
			end
			if (ctrl.go) begin
				mask_q   <= ctrl.mask;
				x_q      <= ctrl.x;
				y_q      <= ctrl.y;
				z_q      <= ctrl.z;
				corner_q <= '0;
				active_q <= 1'b1;
			end else if (active_q) begin
				strobe       <= 1'b1;
				vertex_x     <= {1'b0, x_q} + vfc_pkg::VPOS_W'(offs[2]);
				vertex_y     <= {1'b0, y_q} + vfc_pkg::VPOS_W'(offs[1]);
				vertex_z     <= {1'b0, z_q} + vfc_pkg::VPOS_W'(offs[0]);
				face_dir     <= cur_face;
				corner       <= corner_q;
				vertex_index <= count_q;
				last         <= last_v;
				count_q      <= count_q + 1'b1;
				corner_q     <= corner_q + 1'b1;
				if (corner_q == vfc_pkg::CORNER_LAST) begin
					mask_q <= rest_mask;
				end
				if (last_v) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	assign stat.active = active_q;

endmodule

// File: hdl/vfc_checker.sv
// Port-level checks for the voxel face culling mesher, bound to the top level.
// Depends on vfc_pkg and voxel_face_culling_mesher.
`timescale 1ns / 1ps

module vfc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic [1:0]                 command,
	input logic                       strobe,
	input logic [2:0]                 face_dir,
	input logic [1:0]                 corner,
	input logic [vfc_pkg::VIDX_W-1:0] vertex_index,
	input logic                       last
);

	// results only appear while a command is in flight
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result strobe while not busy");

	// vertices of one cell come back to back with consecutive indices
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe &&
			(vertex_index == $past(vertex_index) + 1'b1))
		else $error("vertex index did not advance by one");

	// corners of a quad advance within the same face
	a_corner_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last && (corner != vfc_pkg::CORNER_LAST) |=>
			(face_dir == $past(face_dir)) && (corner == $past(corner) + 1'b1))
		else $error("corner sequence broken within a face");

	// write and begin transactions finish at once and emit nothing
	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy &&
			((command == vfc_pkg::CMD_WRITE) || (command == vfc_pkg::CMD_BEGIN)) |=>
			!busy && !strobe)
		else $error("write or begin transaction did not finish in one cycle");

	// nothing follows the last vertex of a cell
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result after last vertex");

endmodule

bind voxel_face_culling_mesher vfc_checker u_vfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.command     (command),
	.strobe      (strobe),
	.face_dir    (face_dir),
	.corner      (corner),
	.vertex_index(vertex_index),
	.last        (last)
);

// File: bench/voxel_face_culling_mesher_tb.sv
// Testbench for the voxel face culling mesher: drives write, begin and emit transactions,
// predicts every vertex in a small scoreboard and checks each strobed vertex in order.
// Depends on vfc_pkg and voxel_face_culling_mesher.
`timescale 1ns / 1ps

module voxel_face_culling_mesher_tb;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 12;
	localparam int CHUNK        = vfc_pkg::CHUNK_EDGE_DEF;
	localparam logic [vfc_pkg::CELL_W-1:0] CMAX = '1;
	localparam int BOX          = 3;        // edge of the dense region used by random sequences
	localparam int RANDOM_ITEMS = 410;
	localparam int DRAIN_CYCLES = 60;
	localparam longint CYCLE_LIMIT = 1000000;

	// unused command code, must be ignored
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// corner offsets {dx, dy, dz} of each face quad, corner 0 in the top bits
	localparam logic [11:0] QUAD_OFS [vfc_pkg::FACES] = '{
		12'b001_101_111_011,   // +Z
		12'b100_000_010_110,   // -Z
		12'b010_011_111_110,   // +Y
		12'b100_101_001_000,   // -Y
		12'b101_100_110_111,   // +X
		12'b000_001_011_010    // -X
	};

	typedef struct packed {
		logic [vfc_pkg::VPOS_W-1:0] vx;
		logic [vfc_pkg::VPOS_W-1:0] vy;
		logic [vfc_pkg::VPOS_W-1:0] vz;
		logic [2:0]                 dir;
		logic [1:0]                 crn;
		logic [vfc_pkg::VIDX_W-1:0] idx;
		logic                       lst;
	} vertex_t;

	// Voxel store copy, vertex counter and the vertices still to come
	class mesh_scoreboard;
		logic [vfc_pkg::TYPE_W-1:0] voxel_model [CHUNK*CHUNK*CHUNK];
		logic [vfc_pkg::VIDX_W-1:0] vertex_count;
		vertex_t                    pending_vertices [$];
		int                         mismatches;

		function new();
			foreach (voxel_model[i]) voxel_model[i] = '0;
			vertex_count = '0;
			mismatches = 0;
		endfunction

		function int cell_addr(int x, int y, int z);
			return x + y * CHUNK + z * CHUNK * CHUNK;
		endfunction

		// anything outside the chunk reads as air
		function logic [vfc_pkg::TYPE_W-1:0] read_cell(int x, int y, int z);
			if (x < 0 || x >= CHUNK || y < 0 || y >= CHUNK || z < 0 || z >= CHUNK)
				return '0;
			return voxel_model[cell_addr(x, y, z)];
		endfunction

		// Update the store copy and queue the vertices an accepted transaction causes
		function void note_command(logic [1:0] cmd, logic [vfc_pkg::CELL_W-1:0] x, y, z,
				logic [vfc_pkg::TYPE_W-1:0] btype);
			logic [vfc_pkg::FACES-1:0] open_faces;
			int                        faces_open;
			int                        emitted;
			int                        nx, ny, nz;
			logic [2:0]                fd;
			logic [2:0]                ofs;
			vertex_t                   v;
			case (cmd)
			vfc_pkg::CMD_WRITE: voxel_model[cell_addr(int'(x), int'(y), int'(z))] = btype;
			vfc_pkg::CMD_BEGIN: vertex_count = '0;
			vfc_pkg::CMD_EMIT: begin
				if (read_cell(int'(x), int'(y), int'(z)) == 0)
					return;
				// find exposed faces in +Z, -Z, +Y, -Y, +X, -X order
				faces_open = 0;
				for (int f = 0; f < vfc_pkg::FACES; f++) begin
					nx = int'(x);
					ny = int'(y);
					nz = int'(z);
					fd = 3'(f);
					case (fd)
					vfc_pkg::FACE_POS_Z: nz = nz + 1;
					vfc_pkg::FACE_NEG_Z: nz = nz - 1;
					vfc_pkg::FACE_POS_Y: ny = ny + 1;
					vfc_pkg::FACE_NEG_Y: ny = ny - 1;
					vfc_pkg::FACE_POS_X: nx = nx + 1;
					vfc_pkg::FACE_NEG_X: nx = nx - 1;
					default: ;
					endcase
					open_faces[f] = (read_cell(nx, ny, nz) == 0);
					if (open_faces[f])
						faces_open++;
				end
				// four corners per exposed face, consecutive indices
				emitted = 0;
				for (int f = 0; f < vfc_pkg::FACES; f++) begin
					if (open_faces[f]) begin
						for (int c = 0; c < 4; c++) begin
							ofs = QUAD_OFS[f][11 - 3 * c -: 3];
							v.vx  = vfc_pkg::VPOS_W'(x) + vfc_pkg::VPOS_W'(ofs[2]);
							v.vy  = vfc_pkg::VPOS_W'(y) + vfc_pkg::VPOS_W'(ofs[1]);
							v.vz  = vfc_pkg::VPOS_W'(z) + vfc_pkg::VPOS_W'(ofs[0]);
							v.dir = 3'(f);
							v.crn = 2'(c);
							v.idx = vertex_count;
							v.lst = (emitted == 4 * faces_open - 1);
							vertex_count = vertex_count + 1'b1;
							emitted++;
							pending_vertices.insert(pending_vertices.size(), v);
						end
					end
				end
			end
			default: ;
			endcase
		endfunction

		task report(string what);
			$display("%0t: mismatch: %s", $time, what);
			mismatches++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want, int idx);
			if (got !== want)
				report($sformatf("vertex %0d %s got %0d, want %0d", idx, name, got, want));
		endtask

		// Compare one strobed vertex with the oldest one expected
		task check_vertex(vertex_t got);
			vertex_t want;
			if (pending_vertices.size() == 0) begin
				report($sformatf("vertex with none expected: (%0d,%0d,%0d) dir %0d index %0d",
					got.vx, got.vy, got.vz, got.dir, got.idx));
				return;
			end
			want = pending_vertices.pop_front();
			compare_field("vertex_x", 32'(got.vx), 32'(want.vx), int'(want.idx));
			compare_field("vertex_y", 32'(got.vy), 32'(want.vy), int'(want.idx));
			compare_field("vertex_z", 32'(got.vz), 32'(want.vz), int'(want.idx));
			compare_field("face_dir", 32'(got.dir), 32'(want.dir), int'(want.idx));
			compare_field("corner", 32'(got.crn), 32'(want.crn), int'(want.idx));
			compare_field("vertex_index", 32'(got.idx), 32'(want.idx), int'(want.idx));
			compare_field("last", 32'(got.lst), 32'(want.lst), int'(want.idx));
		endtask
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         busy;
	logic [1:0]                   command = vfc_pkg::CMD_WRITE;
	logic [vfc_pkg::CELL_W-1:0]   cell_x = '0;
	logic [vfc_pkg::CELL_W-1:0]   cell_y = '0;
	logic [vfc_pkg::CELL_W-1:0]   cell_z = '0;
	logic [vfc_pkg::TYPE_W-1:0]   block_type = '0;
	logic                         strobe;
	logic [vfc_pkg::VPOS_W-1:0]   vertex_x;
	logic [vfc_pkg::VPOS_W-1:0]   vertex_y;
	logic [vfc_pkg::VPOS_W-1:0]   vertex_z;
	logic [2:0]                   face_dir;
	logic [1:0]                   corner;
	logic [vfc_pkg::VIDX_W-1:0]   vertex_index;
	logic                         last;

	mesh_scoreboard sb;
	vertex_t        seen_vertex;
	longint         cycle_count = 0;
	int             burst_left = 0;
	int             bx, by, bz;

	voxel_face_culling_mesher dut (.*);

	always #CLK_HALF clk = ~clk;

	// Watchdog: end the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// Sample each strobed vertex mid-cycle
	always @(negedge clk) begin
		if (arst_n && strobe) begin
			seen_vertex.vx  = vertex_x;
			seen_vertex.vy  = vertex_y;
			seen_vertex.vz  = vertex_z;
			seen_vertex.dir = face_dir;
			seen_vertex.crn = corner;
			seen_vertex.idx = vertex_index;
			seen_vertex.lst = last;
			sb.check_vertex(seen_vertex);
		end
	end

	// Present one transaction and hold it until the block takes it; call at a rising edge
	task automatic issue(logic [1:0] cmd, logic [vfc_pkg::CELL_W-1:0] x, y, z,
			logic [vfc_pkg::TYPE_W-1:0] btype);
		logic taken;
		start      <= 1'b1;
		command    <= cmd;
		cell_x     <= x;
		cell_y     <= y;
		cell_z     <= z;
		block_type <= btype;
		do begin
			@(negedge clk);
			taken = (busy === 1'b0);
			@(posedge clk);
		end while (!taken);
		sb.note_command(cmd, x, y, z, btype);
	endtask

	// Drop start for a while, with noise on the idle fields
	task automatic pause(int cycles);
		repeat (cycles) begin
			start      <= 1'b0;
			command    <= 2'($urandom_range(0, 3));
			cell_x     <= vfc_pkg::CELL_W'($urandom_range(0, CMAX));
			cell_y     <= vfc_pkg::CELL_W'($urandom_range(0, CMAX));
			cell_z     <= vfc_pkg::CELL_W'($urandom_range(0, CMAX));
			block_type <= vfc_pkg::TYPE_W'($urandom_range(0, 255));
			@(posedge clk);
		end
	endtask

	// Send in bursts of random length with random gaps between them
	task automatic send(logic [1:0] cmd, logic [vfc_pkg::CELL_W-1:0] x, y, z,
			logic [vfc_pkg::TYPE_W-1:0] btype);
		issue(cmd, x, y, z, btype);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 12);
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 40));
		end
	endtask

	// Pick a small dense region, often against a chunk boundary
	task automatic pick_region();
		case ($urandom_range(0, 3))
		0: bx = 0;
		1: bx = CHUNK - BOX;
		default: bx = $urandom_range(0, CHUNK - BOX);
		endcase
		case ($urandom_range(0, 3))
		0: by = 0;
		1: by = CHUNK - BOX;
		default: by = $urandom_range(0, CHUNK - BOX);
		endcase
		case ($urandom_range(0, 3))
		0: bz = 0;
		1: bz = CHUNK - BOX;
		default: bz = $urandom_range(0, CHUNK - BOX);
		endcase
	endtask

	initial begin
		int         counted;
		int         writes;
		int         emits;
		logic [1:0] cmd;
		sb = new();

		// hold reset, then let the block clear its store behind busy
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: air cell, chunk corners, begin mesh
		send(vfc_pkg::CMD_EMIT, 0, 0, 0, 8'hff);
		send(vfc_pkg::CMD_WRITE, 0, 0, 0, 8'hff);
		send(vfc_pkg::CMD_EMIT, 0, 0, 0, 8'h00);
		send(vfc_pkg::CMD_WRITE, CMAX, CMAX, CMAX, 8'h01);
		send(vfc_pkg::CMD_EMIT, CMAX, CMAX, CMAX, 8'h80);
		send(vfc_pkg::CMD_BEGIN, CMAX, CMAX, CMAX, 8'hff);
		// enclosed solid cell, then a neighbor with five open faces
		send(vfc_pkg::CMD_WRITE, 10, 10, 10, 8'h5a);
		send(vfc_pkg::CMD_WRITE, 10, 10, 11, 8'h01);
		send(vfc_pkg::CMD_WRITE, 10, 10, 9, 8'h02);
		send(vfc_pkg::CMD_WRITE, 10, 11, 10, 8'h04);
		send(vfc_pkg::CMD_WRITE, 10, 9, 10, 8'h08);
		send(vfc_pkg::CMD_WRITE, 11, 10, 10, 8'h10);
		send(vfc_pkg::CMD_WRITE, 9, 10, 10, 8'h20);
		send(vfc_pkg::CMD_EMIT, 10, 10, 10, 8'h00);
		send(vfc_pkg::CMD_EMIT, 10, 10, 11, 8'h40);
		// unused code, clearing a voxel back to air
		send(CMD_UNUSED, CMAX, CMAX, CMAX, 8'hff);
		send(vfc_pkg::CMD_WRITE, 0, 0, 0, 8'h00);
		send(vfc_pkg::CMD_EMIT, 0, 0, 0, 8'h00);
		send(vfc_pkg::CMD_EMIT, CMAX, 0, CMAX, 8'h00);

		// random: mostly fill-and-mesh sequences in a small region, some noise
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) != 0) begin
				pick_region();
				if ($urandom_range(0, 3) == 0) begin
					send(vfc_pkg::CMD_BEGIN, vfc_pkg::CELL_W'($urandom_range(0, CMAX)),
						vfc_pkg::CELL_W'($urandom_range(0, CMAX)),
						vfc_pkg::CELL_W'($urandom_range(0, CMAX)),
						vfc_pkg::TYPE_W'($urandom_range(0, 255)));
					counted++;
				end
				writes = $urandom_range(2, 10);
				emits = $urandom_range(1, 6);
				repeat (writes) begin
					send(vfc_pkg::CMD_WRITE,
						vfc_pkg::CELL_W'(bx + $urandom_range(0, BOX - 1)),
						vfc_pkg::CELL_W'(by + $urandom_range(0, BOX - 1)),
						vfc_pkg::CELL_W'(bz + $urandom_range(0, BOX - 1)),
						vfc_pkg::TYPE_W'(($urandom_range(0, 4) == 0) ? 0
							: $urandom_range(1, 255)));
				end
				repeat (emits) begin
					send(vfc_pkg::CMD_EMIT,
						vfc_pkg::CELL_W'(bx + $urandom_range(0, BOX - 1)),
						vfc_pkg::CELL_W'(by + $urandom_range(0, BOX - 1)),
						vfc_pkg::CELL_W'(bz + $urandom_range(0, BOX - 1)),
						vfc_pkg::TYPE_W'($urandom_range(0, 255)));
				end
				counted += writes + emits;
			end else begin
				cmd = 2'($urandom_range(0, 3));
				send(cmd, vfc_pkg::CELL_W'($urandom_range(0, CMAX)),
					vfc_pkg::CELL_W'($urandom_range(0, CMAX)),
					vfc_pkg::CELL_W'($urandom_range(0, CMAX)),
					vfc_pkg::TYPE_W'($urandom_range(0, 255)));
				if (cmd != CMD_UNUSED)
					counted++;
			end
		end

		// drain: wait for every expected vertex, then a little longer
		pause(1);
		while (sb.pending_vertices.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_vertices.size() != 0)
			sb.report($sformatf("%0d vertices never arrived", sb.pending_vertices.size()));

		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
